[design/mavg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_pkg: shared constants for the moving average filter
// field widths, register map and parameter defaults
// ----------------------------------------------------------------------------
package mavg_pkg;

	// field widths
	localparam int SAMPLE_W = 32;
	localparam int WIN_W    = 7;

	// parameter defaults and reset values
	localparam int MAX_WINDOW_DEF = 64;
	localparam int WINDOW_RESET   = 16;

	// register map: one 32-bit register per word
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 1;
	localparam int ADDR_W    = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_WINDOW = '0;

endpackage

[design/mavg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mavg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/mavg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_div: bit-serial signed divider
// restoring division of a signed running sum by an unsigned count,
// one quotient bit per cycle, truncating toward zero
// ----------------------------------------------------------------------------
module mavg_div #(
	parameter int SUM_W = 38
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [SUM_W-1:0]           dividend,
	input  logic [mavg_pkg::WIN_W-1:0]        divisor,
	output logic                              done,
	output logic [mavg_pkg::SAMPLE_W-1:0]     quotient
);

	import mavg_pkg::*;

	localparam int CNT_W = $clog2(SUM_W);

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_ABS,
		DV_RUN,
		DV_FIX
	} dv_state_t;

	dv_state_t           state_q;
	logic [SUM_W-1:0]    num_q;
	logic [WIN_W-1:0]    den_q;
	logic [WIN_W-1:0]    rem_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic [SAMPLE_W-1:0] quot_q;

	logic [WIN_W:0]      trial;
	logic [WIN_W:0]      diff;
	logic                qbit;

	// one trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, num_q[SUM_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						num_q   <= dividend;
						den_q   <= divisor;
						neg_q   <= dividend[SUM_W-1];
						state_q <= DV_ABS;
					end
				end
				DV_ABS: begin
					// magnitude of the sum, most negative value fits unsigned
					num_q   <= neg_q ? (~num_q + SUM_W'(1)) : num_q;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= DV_RUN;
				end
				DV_RUN: begin
					rem_q <= qbit ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
					num_q <= {num_q[SUM_W-2:0], qbit};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= DV_FIX;
					end
				end
				DV_FIX: begin
					quot_q  <= neg_q ? (~num_q[SAMPLE_W-1:0] + SAMPLE_W'(1))
					                 : num_q[SAMPLE_W-1:0];
					done_q  <= 1'b1;
					state_q <= DV_IDLE;
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

[design/moving_average_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_filter_top: running-sum moving average
// mean of the most recent signed samples over a configurable window,
// ring store for old samples, bit-serial divider for the mean
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------
//  input     in         in_valid / in_stall    sample (32b signed)
//  output    out        out_valid / out_stall  average (32b signed),
//                                              samples_held (7b)
//  config    in         apb write, pready=1    window_length at byte addr 0
//
//  an item passes the states sub, add, div and out from acceptance to result;
//  the bit-serial divider runs in div, and out waits until the output is free
//  the next item is taken in the cycle after the result is loaded, so no new
//  item is taken before the last one is through
//  a result waiting in the output register does not hold back the next item
//  reset (window 16) and any window_length write clear count, pointer and sum
// ----------------------------------------------------------------------------
module moving_average_filter_top #(
	parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mavg_pkg::ADDR_W-1:0]          paddr,
	input  logic [mavg_pkg::DATA_W-1:0]          pwdata,
	output logic [mavg_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,

	// input items
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [mavg_pkg::SAMPLE_W-1:0] sample,

	// result items
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mavg_pkg::SAMPLE_W-1:0] average,
	output logic [mavg_pkg::WIN_W-1:0]           samples_held
);

	import mavg_pkg::*;

	// the register field is 7 bits, so the usable window never exceeds 127
	localparam int WMAX   = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
	localparam int WRST   = (WINDOW_RESET < WMAX) ? WINDOW_RESET : WMAX;
	localparam int SUM_W  = SAMPLE_W + $clog2(WMAX);
	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int CMP_W  = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;

	localparam logic [WIN_W-1:0] WMAX_V = WIN_W'(WMAX);
	localparam logic [WIN_W-1:0] WRST_V = WIN_W'(WRST);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                     state_q;
	logic [WIN_W-1:0]           window_q;
	logic [WIN_W-1:0]           fill_q;
	logic [PTR_W-1:0]           wp_q;
	logic [PTR_W-1:0]           ptr_q;
	logic                       full_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] average_q;
	logic [WIN_W-1:0]           held_q;

	logic                       cfg_wr;
	logic [WIN_W-1:0]           cfg_val;
	logic [WIN_W-1:0]           cfg_win;
	logic                       accept;
	logic [PTR_W-1:0]           ptr_eff;
	logic [PTR_W-1:0]           ptr_next;
	logic                       full;
	logic [SAMPLE_W-1:0]        old_sample;
	logic signed [SUM_W-1:0]    sum_add;
	logic                       div_start;
	logic                       div_done;
	logic [SAMPLE_W-1:0]        div_quot;
	logic                       out_free;

	// apb: always ready, window_length is the only register
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready
	                 && (paddr[ADDR_W-1:2] == REG_WINDOW);
	assign cfg_val = pwdata[WIN_W-1:0];

	// zero means a window of one, too large saturates
	always_comb begin
		if (cfg_val == '0) begin
			cfg_win = WIN_W'(1);
		end else if (cfg_val > WMAX_V) begin
			cfg_win = WMAX_V;
		end else begin
			cfg_win = cfg_val;
		end
	end

	assign prdata = (paddr[ADDR_W-1:2] == REG_WINDOW) ? DATA_W'(window_q) : '0;

	// one item at a time; the output register parts the result from the next item
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// pointer for this item, with its wrap past the window end
	always_comb begin
		if (CMP_W'(wp_q) >= CMP_W'(window_q)) begin
			ptr_eff = '0;
		end else begin
			ptr_eff = wp_q;
		end
		if (CMP_W'(ptr_eff) + CMP_W'(1) >= CMP_W'(window_q)) begin
			ptr_next = '0;
		end else begin
			ptr_next = ptr_eff + PTR_W'(1);
		end
	end

	assign full = (fill_q >= window_q);

	// sum plus the new sample, feeds both the sum register and the divider
	assign sum_add   = sum_q + {{(SUM_W - SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
	assign div_start = (state_q == ST_ADD);

	assign out_free = !out_valid_q || !out_stall;

	// ring of past samples: read the oldest on accept, overwrite it in the next cycle
	mavg_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_SUB),
		.waddr (ptr_q),
		.wdata (sample_q),
		.re    (accept),
		.raddr (ptr_eff),
		.rdata (old_sample)
	);

	mavg_div #(
		.SUM_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_add),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WRST_V;
			fill_q      <= '0;
			wp_q        <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result leaves when the far side takes it
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// config writes must come only while idle; the block itself does not enforce it
			if (cfg_wr) begin
				window_q <= cfg_win;
				fill_q   <= '0;
				wp_q     <= '0;
				sum_q    <= '0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sample_q <= sample;
						ptr_q    <= ptr_eff;
						full_q   <= full;
						fill_q   <= full ? window_q : (fill_q + WIN_W'(1));
						wp_q     <= ptr_next;
						state_q  <= ST_SUB;
					end
				end
				ST_SUB: begin
					// drop the oldest sample once the window is full
					if (full_q) begin
						sum_q <= sum_q
						         - {{(SUM_W - SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q   <= sum_add;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						average_q   <= div_quot;
						held_q      <= fill_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign average      = average_q;
	assign samples_held = held_q;

endmodule
